FILE: sv/drum_step_sequencer_unit_macros.svh
// Assertion macros for the drum step sequencer unit.
`ifndef DRUM_STEP_SEQUENCER_UNIT_MACROS_SVH
`define DRUM_STEP_SEQUENCER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DSS_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define DSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define DSS_ASSERT_HOLD(lbl, cond, msg)
`define DSS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/dss_pkg.sv
// Shared types, constants and pattern table of the drum step sequencer.
package dss_pkg;

  localparam int NUM_TRACKS = 4;
  localparam int STEP_W     = 5;
  localparam int LEN_W      = 6;
  localparam int PAT_W      = 4;
  localparam int PULSE_W    = 8;
  localparam int GATE_CNT_W = 16;
  localparam int ADDR_W     = 3;

  typedef enum logic {
    REG_PULSES_PER_STEP = 1'b0,
    REG_GATE_LENGTH     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             req_type;
    logic             clock_level;
    logic             reset_level;
    logic [PAT_W-1:0] pattern_id;
  } in_beat_t;

  typedef struct packed {
    logic              kick_gate;
    logic              snare_gate;
    logic              hihat_gate;
    logic              ghost_gate;
    logic [STEP_W-1:0] step_now;
  } out_beat_t;

  typedef struct packed {
    logic              en;
    logic [PAT_W-1:0]  pat;
    logic [STEP_W-1:0] step;
  } rom_req_t;

  function automatic logic [LEN_W-1:0] pat_len(input logic [PAT_W-1:0] id);
    logic [LEN_W-1:0] len;
    unique case (id)
      4'd5:    len = 6'd32;
      4'd7:    len = 6'd24;
      default: len = 6'd16;
    endcase
    return len;
  endfunction

  // bit 0 kick, 1 snare, 2 hihat, 3 ghost
  function automatic logic [NUM_TRACKS-1:0] pat_hits(input logic [PAT_W-1:0] id,
                                                     input logic [STEP_W-1:0] step);
    logic [NUM_TRACKS-1:0][31:0] m;
    logic [NUM_TRACKS-1:0]       h;
    unique case (id)
      4'd0:    m = {32'h0000, 32'h5555, 32'h1010, 32'h0401};
      4'd1:    m = {32'h0000, 32'h5555, 32'h4010, 32'h0401};
      4'd2:    m = {32'hA280, 32'h5555, 32'h0410, 32'h0001};
      4'd3:    m = {32'hA000, 32'h5555, 32'h0410, 32'h0101};
      4'd4:    m = {32'h0000, 32'h5555, 32'h1000, 32'h0041};
      4'd5:    m = {32'h00000000, 32'h55555555, 32'h01111110, 32'h40000001};
      4'd6:    m = {32'h0000, 32'h5555, 32'h0100, 32'h0001};
      4'd7:    m = {32'h000000, 32'h555555, 32'h040040, 32'h041041};
      4'd8:    m = {32'h0040, 32'h5555, 32'h1290, 32'h0401};
      4'd9:    m = {32'h0808, 32'h5D5D, 32'h1010, 32'h2121};
      default: m = '0;
    endcase
    for (int t = 0; t < NUM_TRACKS; t++) begin
      h[t] = m[t][step];
    end
    return h;
  endfunction

endpackage

FILE: sv/drum_step_sequencer_unit.sv
// Top level of the four-track drum step sequencer with clock divider.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_data  (in_beat_t)
//  out_    | output    | out_valid/out_stall| out_data (out_beat_t)
//  cfg     | input     | psel/penable/pready| paddr, pwdata, prdata
//
// One beat per cycle while in_stall is low; sample beats raise out_valid.
// Latency is set by the registered pattern ROM read and the output register.
// Pattern change beats update the queue only and give no result.
// rst_n is synchronous: counters, queue and gates clear at once.
// in_stall rises only while the ROM stage and the output register are both full
// and out_stall is high.
module drum_step_sequencer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dss_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dss_pkg::out_beat_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dss_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dss_pkg::*;

  logic [PULSE_W-1:0]    pps_r;
  logic [GATE_CNT_W-1:0] gate_len_r;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  logic                  clk_prev_r, clk_prev_nxt;
  logic                  rst_prev_r, rst_prev_nxt;
  logic [PULSE_W-1:0]    pulse_r, pulse_nxt, pulse_inc;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [PAT_W-1:0]      active_r, active_nxt;
  logic                  pend_r, pend_nxt;
  logic [PAT_W-1:0]      pend_pat_r, pend_pat_nxt;
  logic                  adv;

  logic                  in_acc;
  logic                  tick;
  rom_req_t              rom_req;
  logic [NUM_TRACKS-1:0] hits;

  logic                  s1_valid_r;
  logic                  s1_adv_r;
  logic [STEP_W-1:0]     s1_step_r;
  logic                  s1_move;

  logic [NUM_TRACKS-1:0][GATE_CNT_W-1:0] gate_r;
  logic [NUM_TRACKS-1:0][GATE_CNT_W-1:0] gate_nxt;
  logic [NUM_TRACKS-1:0][GATE_CNT_W-1:0] gate_cur;
  logic [NUM_TRACKS-1:0]                 gate_on;
  logic                  out_valid_r;
  out_beat_t             out_data_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_PULSES_PER_STEP: prdata = {24'd0, pps_r};
      REG_GATE_LENGTH:     prdata = {16'd0, gate_len_r};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pps_r      <= PULSE_W'(6);
      gate_len_r <= GATE_CNT_W'(480);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PULSES_PER_STEP: pps_r      <= pwdata[PULSE_W-1:0];
        REG_GATE_LENGTH:     gate_len_r <= pwdata[GATE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;
  assign tick     = in_acc && !in_data.req_type;

  // counters, pattern queue and step advance
  always_comb begin
    clk_prev_nxt = clk_prev_r;
    rst_prev_nxt = rst_prev_r;
    pulse_nxt    = pulse_r;
    pulse_inc    = '0;
    step_nxt     = step_r;
    active_nxt   = active_r;
    pend_nxt     = pend_r;
    pend_pat_nxt = pend_pat_r;
    adv          = 1'b0;
    if (in_acc && in_data.req_type) begin
      pend_pat_nxt = in_data.pattern_id;
      pend_nxt     = 1'b1;
    end else if (tick) begin
      if (in_data.reset_level && !rst_prev_r) begin
        step_nxt  = '0;
        pulse_nxt = '0;
      end
      rst_prev_nxt = in_data.reset_level;
      if (in_data.clock_level && !clk_prev_r) begin
        pulse_inc = pulse_nxt + PULSE_W'(1);
        if (pulse_inc >= pps_r) begin
          adv       = 1'b1;
          pulse_nxt = '0;
          if ({1'b0, step_nxt} + LEN_W'(1) >= pat_len(active_r)) begin
            step_nxt = '0;
          end else begin
            step_nxt = step_nxt + STEP_W'(1);
          end
          if (step_nxt == '0 && pend_r) begin
            active_nxt = pend_pat_r;
            pend_nxt   = 1'b0;
          end
        end else begin
          pulse_nxt = pulse_inc;
        end
      end
      clk_prev_nxt = in_data.clock_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_prev_r <= 1'b0;
      rst_prev_r <= 1'b0;
      pulse_r    <= '0;
      step_r     <= '0;
      active_r   <= '0;
      pend_r     <= 1'b0;
      pend_pat_r <= '0;
    end else begin
      clk_prev_r <= clk_prev_nxt;
      rst_prev_r <= rst_prev_nxt;
      pulse_r    <= pulse_nxt;
      step_r     <= step_nxt;
      active_r   <= active_nxt;
      pend_r     <= pend_nxt;
      pend_pat_r <= pend_pat_nxt;
    end
  end

  assign rom_req.en   = tick && adv;
  assign rom_req.pat  = active_nxt;
  assign rom_req.step = step_nxt;

  dss_pattern_rom u_rom (
    .clk    (clk),
    .req    (rom_req),
    .hits_r (hits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= tick;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_adv_r  <= adv;
      s1_step_r <= step_nxt;
    end
  end

  // load on advance, then count down
  always_comb begin
    for (int t = 0; t < NUM_TRACKS; t++) begin
      gate_cur[t] = s1_adv_r ? (hits[t] ? gate_len_r : '0) : gate_r[t];
      gate_on[t]  = gate_cur[t] != '0;
      gate_nxt[t] = gate_on[t] ? gate_cur[t] - GATE_CNT_W'(1) : gate_cur[t];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      gate_r      <= gate_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.kick_gate  <= gate_on[0];
      out_data_r.snare_gate <= gate_on[1];
      out_data_r.hihat_gate <= gate_on[2];
      out_data_r.ghost_gate <= gate_on[3];
      out_data_r.step_now   <= s1_step_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "drum_step_sequencer_unit_macros.svh"

  `DSS_ASSERT_IMPL(a_stall_needs_beat, in_stall, s1_valid_r, "input stalled with empty stage")
  `DSS_ASSERT_HOLD(a_step_in_range, {1'b0, step_r} < pat_len(active_r), "step beyond pattern")
  `DSS_ASSERT_IMPL(a_load_at_wrap, $fell(pend_r), step_r == '0, "pattern loaded off step 0")

endmodule

FILE: sv/dss_pattern_rom.sv
// Synchronous pattern ROM: one registered read of four track bits per cycle while req.en is high.
module dss_pattern_rom (
  input  logic                             clk,
  input  dss_pkg::rom_req_t                req,
  output logic [dss_pkg::NUM_TRACKS-1:0]   hits_r
);
  import dss_pkg::*;

  always_ff @(posedge clk) begin
    if (req.en) begin
      hits_r <= pat_hits(req.pat, req.step);
    end
  end

endmodule
